// ===== src/segment_intersection_assert.svh =====
// Assertion macros for the segment intersection checker.
// Needs a clk_i and an active-low rst_ni in the scope of each use.
`ifndef SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_INTERSECTION_ASSERT_SVH

// Check a property at each rising edge outside reset.
`define SI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at each rising edge, reset included.
`define SI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/segint_pkg.sv =====
// Shared widths, codes and latencies of the segment intersection block.
// No dependencies.
package segint_pkg;

  localparam int COORD_W   = 32;              // Q16.16 coordinate
  localparam int TOL_W     = 31;              // unsigned tolerance
  localparam int DIFF_W    = COORD_W + 1;     // coordinate difference
  localparam int PROD_W    = 2 * DIFF_W;      // product of two differences
  localparam int SUM_W     = PROD_W + 1;      // cross product, squared length
  localparam int QUOT_BITS = 34;              // quotient bits before saturation
  localparam int MUL_LAT   = 3;               // stages of the limb multiplier
  localparam int DIV_LAT   = QUOT_BITS + 1;   // stages of the divider

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic signed [1:0] {
    ORIENT_NONE = 2'sb00,
    ORIENT_POS  = 2'sb01,
    ORIENT_NEG  = 2'sb11
  } orient_e;

endpackage

// ===== src/segint_if.sv =====
// Valid/ready channels of the segment intersection block.
// Depends on segint_pkg.
interface segint_in_if import segint_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t a_start_x;
  coord_t a_start_y;
  coord_t a_end_x;
  coord_t a_end_y;
  coord_t b_start_x;
  coord_t b_start_y;
  coord_t b_end_x;
  coord_t b_end_y;

  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink   (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface segint_out_if import segint_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [1:0]  orientation;
  coord_t             hit_x;
  coord_t             hit_y;

  modport source (output valid, orientation, hit_x, hit_y, input ready);
  modport sink   (input valid, orientation, hit_x, hit_y, output ready);
endinterface

// ===== src/segment_intersection.sv =====
// Segment intersection with distance tolerance, parametric form.
// Input channel in_i carries two segments (eight signed Q16.16 values);
// output channel out_o carries orientation and the hit point, or
// orientation 0 and a zero point when the segments miss or are parallel.
// cfg_we_i/cfg_wdata_i write the tolerance (unsigned Q15.16); write it only
// while no item is in flight. Reset sets the tolerance to 0 and empties
// the pipeline.
// Throughput: one item per cycle while in_i.ready is high. The depth is set
// by the limb multiplier and the restoring divider on the hit point; the
// two chained limb multipliers of the tolerance test are delayed to match.
// When the receiver stalls, the output register holds its item and one
// more item drops into a skid register; only then does in_i.ready fall,
// and the whole pipeline freezes with nothing lost or repeated.
// Depends on segint_pkg, segint_if, segint_mul, segint_div, segint_delay.
module segment_intersection import segint_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [TOL_W-1:0] cfg_wdata_i,
  segint_in_if.sink        in_i,
  segint_out_if.source     out_o
);

  localparam int M_W     = SUM_W + DIFF_W;          // |n| * |d|
  localparam int NUM_W   = M_W + 1;
  localparam int DV_W    = SUM_W + 1;
  localparam int V2_W    = 2 * SUM_W;
  localparam int TD_W    = TOL_W + SUM_W;
  localparam int PA_W    = V2_W + SUM_W;
  localparam int LIM_W   = 2 * TD_W;
  localparam int CMP_W   = (PA_W > LIM_W) ? PA_W : LIM_W;
  localparam int SIDE_W  = 2 + 2 * COORD_W + SUM_W;
  localparam int OD_DLY  = 2 * MUL_LAT;
  localparam int HIT_DLY = DIV_LAT - MUL_LAT;
  localparam int LAT     = 5 + MUL_LAT + 1 + DIV_LAT + 1;
  localparam int SUM_W2  = QUOT_BITS + 2;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  // Amount by which a position lies outside 0..den
  function automatic logic [SUM_W-1:0] excess(input logic signed [SUM_W-1:0] n,
                                              input logic signed [SUM_W-1:0] d);
    if (n < 0) begin
      return -n;
    end else if (n > d) begin
      return n - d;
    end
    return '0;
  endfunction

  // Start plus signed quotient, saturated to a coordinate
  function automatic coord_t place(input coord_t start,
                                   input logic [QUOT_BITS-1:0] q,
                                   input logic ovf, input logic neg);
    logic signed [SUM_W2-1:0] qs;
    logic signed [SUM_W2-1:0] s;
    qs = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    s  = SUM_W2'(start) + qs;
    if (ovf) begin
      return neg ? COORD_MIN : COORD_MAX;
    end
    if (s < SUM_W2'(COORD_MIN)) begin
      return COORD_MIN;
    end
    if (s > SUM_W2'(COORD_MAX)) begin
      return COORD_MAX;
    end
    return s[COORD_W-1:0];
  endfunction

  logic             en;
  logic [LAT-1:0]   vld_q;
  logic [TOL_W-1:0] tol_q;

  // stage 1
  logic signed [DIFF_W-1:0] ax_q, ay_q, bx_q, by_q, ux_q, uy_q;
  coord_t                   x0_1_q, y0_1_q;
  // stage 2
  logic signed [PROD_W-1:0] pd1_q, pd2_q, pa1_q, pa2_q, pb1_q, pb2_q;
  logic signed [PROD_W-1:0] la1_q, la2_q, lb1_q, lb2_q;
  logic signed [DIFF_W-1:0] ax_2_q, ay_2_q;
  coord_t                   x0_2_q, y0_2_q;
  // stage 3
  logic signed [SUM_W-1:0]  den_q, na_q, nb_q, la_q, lb_q;
  logic signed [DIFF_W-1:0] ax_3_q, ay_3_q;
  coord_t                   x0_3_q, y0_3_q;
  // stage 4
  logic signed [SUM_W-1:0]  denp_q, nap_q, nbp_q, la_4_q, lb_4_q;
  logic signed [DIFF_W-1:0] ax_4_q, ay_4_q;
  orient_e                  orient_4_q;
  logic                     dz_4_q;
  coord_t                   x0_4_q, y0_4_q;
  // stage 5
  logic [SUM_W-1:0]         va_q, vb_q, mna_q, denp_5_q, la_5_q, lb_5_q;
  logic [DIFF_W-1:0]        max_q, may_q;
  logic                     sx_q, sy_q, dz_5_q;
  orient_e                  orient_5_q;
  coord_t                   x0_5_q, y0_5_q;

  // first multiplier rank, stage 8
  logic [V2_W-1:0] va2, vb2;
  logic [TD_W-1:0] td;
  logic [M_W-1:0]  mx, my;
  logic [SUM_W-1:0] la_8, lb_8;
  logic [SIDE_W-1:0] side_5, side_8;
  logic [SUM_W-1:0]  denp_8;
  coord_t            x0_8, y0_8;
  logic              sx_8, sy_8;

  // second multiplier rank, stage 11
  logic [PA_W-1:0]  pa, pb;
  logic [LIM_W-1:0] lim;
  logic [2:0]       od_5, od_11;

  // stage 9
  logic [NUM_W-1:0]  numx_q, numy_q;
  logic [DV_W-1:0]   dv_q;
  logic [COORD_W:0]  sidex_q, sidey_q;

  // stage 12 and its delay
  logic       hit_12_q;
  orient_e    orient_12_q;
  logic [2:0] ho_44;

  // divider outputs, stage 44
  logic [QUOT_BITS-1:0] qx, qy;
  logic                 ovfx, ovfy;
  logic [COORD_W:0]     sidex_44, sidey_44;

  // stage 45 and output buffer
  orient_e fin_or_q;
  coord_t  fin_x_q, fin_y_q;
  logic    p_valid, take;
  logic    out_valid_q, skid_valid_q;
  orient_e out_or_q, skid_or_q;
  coord_t  out_x_q, out_y_q, skid_x_q, skid_y_q;

  // Freeze the pipeline while the skid register is full
  assign en         = !skid_valid_q;
  assign in_i.ready = en;
  assign p_valid    = vld_q[LAT-1];

  // Hold the tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // Stages 1 to 5: differences, products, cross products, sign fix, excess
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q   <= DIFF_W'(in_i.a_end_x) - DIFF_W'(in_i.a_start_x);
      ay_q   <= DIFF_W'(in_i.a_end_y) - DIFF_W'(in_i.a_start_y);
      bx_q   <= DIFF_W'(in_i.b_end_x) - DIFF_W'(in_i.b_start_x);
      by_q   <= DIFF_W'(in_i.b_end_y) - DIFF_W'(in_i.b_start_y);
      ux_q   <= DIFF_W'(in_i.a_start_x) - DIFF_W'(in_i.b_start_x);
      uy_q   <= DIFF_W'(in_i.a_start_y) - DIFF_W'(in_i.b_start_y);
      x0_1_q <= in_i.a_start_x;
      y0_1_q <= in_i.a_start_y;

      pd1_q  <= ax_q * by_q;
      pd2_q  <= ay_q * bx_q;
      pa1_q  <= bx_q * uy_q;
      pa2_q  <= by_q * ux_q;
      pb1_q  <= ax_q * uy_q;
      pb2_q  <= ay_q * ux_q;
      la1_q  <= ax_q * ax_q;
      la2_q  <= ay_q * ay_q;
      lb1_q  <= bx_q * bx_q;
      lb2_q  <= by_q * by_q;
      ax_2_q <= ax_q;
      ay_2_q <= ay_q;
      x0_2_q <= x0_1_q;
      y0_2_q <= y0_1_q;

      den_q  <= SUM_W'(pd1_q) - SUM_W'(pd2_q);
      na_q   <= SUM_W'(pa1_q) - SUM_W'(pa2_q);
      nb_q   <= SUM_W'(pb1_q) - SUM_W'(pb2_q);
      la_q   <= SUM_W'(la1_q) + SUM_W'(la2_q);
      lb_q   <= SUM_W'(lb1_q) + SUM_W'(lb2_q);
      ax_3_q <= ax_2_q;
      ay_3_q <= ay_2_q;
      x0_3_q <= x0_2_q;
      y0_3_q <= y0_2_q;

      denp_q     <= den_q[SUM_W-1] ? -den_q : den_q;
      nap_q      <= den_q[SUM_W-1] ? -na_q : na_q;
      nbp_q      <= den_q[SUM_W-1] ? -nb_q : nb_q;
      orient_4_q <= den_q[SUM_W-1] ? ORIENT_POS : ORIENT_NEG;
      dz_4_q     <= (den_q == '0);
      la_4_q     <= la_q;
      lb_4_q     <= lb_q;
      ax_4_q     <= ax_3_q;
      ay_4_q     <= ay_3_q;
      x0_4_q     <= x0_3_q;
      y0_4_q     <= y0_3_q;

      va_q       <= excess(nap_q, denp_q);
      vb_q       <= excess(nbp_q, denp_q);
      mna_q      <= nap_q[SUM_W-1] ? -nap_q : nap_q;
      max_q      <= ax_4_q[DIFF_W-1] ? -ax_4_q : ax_4_q;
      may_q      <= ay_4_q[DIFF_W-1] ? -ay_4_q : ay_4_q;
      sx_q       <= nap_q[SUM_W-1] ^ ax_4_q[DIFF_W-1];
      sy_q       <= nap_q[SUM_W-1] ^ ay_4_q[DIFF_W-1];
      denp_5_q   <= denp_q;
      la_5_q     <= la_4_q;
      lb_5_q     <= lb_4_q;
      dz_5_q     <= dz_4_q;
      orient_5_q <= orient_4_q;
      x0_5_q     <= x0_4_q;
      y0_5_q     <= y0_4_q;
    end
  end

  // First multiplier rank: squared excess, tol*den, point numerators
  segint_mul #(.WA(SUM_W), .WB(SUM_W)) u_mul_va2 (
    .clk_i, .en_i(en), .a_i(va_q), .b_i(va_q), .p_o(va2));
  segint_mul #(.WA(SUM_W), .WB(SUM_W)) u_mul_vb2 (
    .clk_i, .en_i(en), .a_i(vb_q), .b_i(vb_q), .p_o(vb2));
  segint_mul #(.WA(TOL_W), .WB(SUM_W)) u_mul_td (
    .clk_i, .en_i(en), .a_i(tol_q), .b_i(denp_5_q), .p_o(td));
  segint_mul #(.WA(SUM_W), .WB(DIFF_W)) u_mul_mx (
    .clk_i, .en_i(en), .a_i(mna_q), .b_i(max_q), .p_o(mx));
  segint_mul #(.WA(SUM_W), .WB(DIFF_W)) u_mul_my (
    .clk_i, .en_i(en), .a_i(mna_q), .b_i(may_q), .p_o(my));

  segint_delay #(.W(SUM_W), .N(MUL_LAT)) u_dly_la (
    .clk_i, .en_i(en), .d_i(la_5_q), .q_o(la_8));
  segint_delay #(.W(SUM_W), .N(MUL_LAT)) u_dly_lb (
    .clk_i, .en_i(en), .d_i(lb_5_q), .q_o(lb_8));

  assign side_5 = {sx_q, sy_q, x0_5_q, y0_5_q, denp_5_q};
  segint_delay #(.W(SIDE_W), .N(MUL_LAT)) u_dly_side (
    .clk_i, .en_i(en), .d_i(side_5), .q_o(side_8));
  assign {sx_8, sy_8, x0_8, y0_8, denp_8} = side_8;

  // Second multiplier rank: excess^2 * len^2 against (tol*den)^2
  segint_mul #(.WA(V2_W), .WB(SUM_W)) u_mul_pa (
    .clk_i, .en_i(en), .a_i(va2), .b_i(la_8), .p_o(pa));
  segint_mul #(.WA(V2_W), .WB(SUM_W)) u_mul_pb (
    .clk_i, .en_i(en), .a_i(vb2), .b_i(lb_8), .p_o(pb));
  segint_mul #(.WA(TD_W), .WB(TD_W)) u_mul_lim (
    .clk_i, .en_i(en), .a_i(td), .b_i(td), .p_o(lim));

  assign od_5 = {dz_5_q, orient_5_q};
  segint_delay #(.W(3), .N(OD_DLY)) u_dly_od (
    .clk_i, .en_i(en), .d_i(od_5), .q_o(od_11));

  // Stage 12: tolerance test on both segments
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_12_q    <= !od_11[2] && (CMP_W'(pa) <= CMP_W'(lim)) &&
                     (CMP_W'(pb) <= CMP_W'(lim));
      orient_12_q <= orient_e'(od_11[1:0]);
    end
  end

  segint_delay #(.W(3), .N(HIT_DLY)) u_dly_hit (
    .clk_i, .en_i(en), .d_i({hit_12_q, orient_12_q}), .q_o(ho_44));

  // Stage 9: rounding numerator 2m+den over divisor 2den
  always_ff @(posedge clk_i) begin
    if (en) begin
      numx_q  <= {mx, 1'b0} + NUM_W'(denp_8);
      numy_q  <= {my, 1'b0} + NUM_W'(denp_8);
      dv_q    <= {denp_8, 1'b0};
      sidex_q <= {sx_8, x0_8};
      sidey_q <= {sy_8, y0_8};
    end
  end

  segint_div #(.WN(NUM_W), .WD(DV_W), .WQ(QUOT_BITS), .WS(COORD_W + 1)) u_div_x (
    .clk_i, .en_i(en), .num_i(numx_q), .div_i(dv_q), .side_i(sidex_q),
    .quo_o(qx), .ovf_o(ovfx), .side_o(sidex_44));
  segint_div #(.WN(NUM_W), .WD(DV_W), .WQ(QUOT_BITS), .WS(COORD_W + 1)) u_div_y (
    .clk_i, .en_i(en), .num_i(numy_q), .div_i(dv_q), .side_i(sidey_q),
    .quo_o(qy), .ovf_o(ovfy), .side_o(sidey_44));

  // Stage 45: place the point, zero everything on a miss
  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_or_q <= ho_44[2] ? orient_e'(ho_44[1:0]) : ORIENT_NONE;
      fin_x_q  <= ho_44[2] ? place(sidex_44[COORD_W-1:0], qx, ovfx, sidex_44[COORD_W])
                           : '0;
      fin_y_q  <= ho_44[2] ? place(sidey_44[COORD_W-1:0], qy, ovfy, sidey_44[COORD_W])
                           : '0;
    end
  end

  // Output register with skid: drop the arriving item into skid on a stall
  assign take = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= p_valid;
      end
    end else if (en && p_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) begin
        out_or_q <= skid_or_q;
        out_x_q  <= skid_x_q;
        out_y_q  <= skid_y_q;
      end else begin
        out_or_q <= fin_or_q;
        out_x_q  <= fin_x_q;
        out_y_q  <= fin_y_q;
      end
    end else if (en) begin
      skid_or_q <= fin_or_q;
      skid_x_q  <= fin_x_q;
      skid_y_q  <= fin_y_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.orientation = out_or_q;
  assign out_o.hit_x       = out_x_q;
  assign out_o.hit_y       = out_y_q;

endmodule

// ===== src/segint_delay.sv =====
// Enabled delay line that carries side data beside the arithmetic stages.
// No dependencies.
module segint_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  // Shift one stage per enabled cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[N-1];

endmodule

// ===== src/segint_mul.sv =====
// Pipelined unsigned multiplier built from 32x32 limb products.
// Stages: limb products, row sums, final sum. No dependencies.
module segint_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [WA-1:0]   a_i,
  input  logic [WB-1:0]   b_i,
  output logic [WA+WB-1:0] p_o
);

  localparam int NA  = (WA + 31) / 32;
  localparam int NB  = (WB + 31) / 32;
  localparam int RW  = NB * 32 + 32;
  localparam int FW  = (NA + NB) * 32;

  logic [NA*32-1:0] a_x;
  logic [NB*32-1:0] b_x;
  logic [63:0]      pp_q  [NA][NB];
  logic [RW-1:0]    row_d [NA];
  logic [RW-1:0]    row_q [NA];
  logic [FW-1:0]    sum_d;
  logic [WA+WB-1:0] p_q;

  assign a_x = (NA*32)'(a_i);
  assign b_x = (NB*32)'(b_i);

  // Sum each row of limb products
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (RW'(pp_q[i][j]) << (32 * j));
      end
    end
  end

  // Sum the rows
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      sum_d = sum_d + (FW'(row_q[i]) << (32 * i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= 64'(a_x[32*i +: 32]) * 64'(b_x[32*j +: 32]);
        end
        row_q[i] <= row_d[i];
      end
      p_q <= sum_d[WA+WB-1:0];
    end
  end

  assign p_o = p_q;

endmodule

// ===== src/segint_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit. No dependencies.
module segint_div #(
  parameter int WN = 64,
  parameter int WD = 32,
  parameter int WQ = 32,
  parameter int WS = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [WN-1:0] num_i,
  input  logic [WD-1:0] div_i,
  input  logic [WS-1:0] side_i,
  output logic [WQ-1:0] quo_o,
  output logic          ovf_o,
  output logic [WS-1:0] side_o
);

  localparam int WR = ((WN > WD + WQ) ? WN : WD + WQ) + 1;

  logic [WR-1:0] rem_d  [WQ+1];
  logic [WR-1:0] rem_q  [WQ+1];
  logic [WQ-1:0] quo_d  [WQ+1];
  logic [WQ-1:0] quo_q  [WQ+1];
  logic [WD-1:0] dv_q   [WQ+1];
  logic          ovf_q  [WQ+1];
  logic [WS-1:0] side_q [WQ+1];

  // Trial subtract of the shifted divisor, one bit per stage
  always_comb begin
    rem_d[0] = WR'(num_i);
    quo_d[0] = '0;
    for (int k = 1; k <= WQ; k++) begin
      if (rem_q[k-1] >= (WR'(dv_q[k-1]) << (WQ - k))) begin
        rem_d[k] = rem_q[k-1] - (WR'(dv_q[k-1]) << (WQ - k));
        quo_d[k] = quo_q[k-1] | (WQ'(1) << (WQ - k));
      end else begin
        rem_d[k] = rem_q[k-1];
        quo_d[k] = quo_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_d[0];
      quo_q[0]  <= quo_d[0];
      dv_q[0]   <= div_i;
      ovf_q[0]  <= (WR'(num_i) >= (WR'(div_i) << WQ));
      side_q[0] <= side_i;
      for (int k = 1; k <= WQ; k++) begin
        rem_q[k]  <= rem_d[k];
        quo_q[k]  <= quo_d[k];
        dv_q[k]   <= dv_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign quo_o  = quo_q[WQ];
  assign ovf_o  = ovf_q[WQ];
  assign side_o = side_q[WQ];

endmodule

// ===== src/segint_chk.sv =====
// Port-level checks of the segment intersection block, bound to the top.
// Depends on segint_pkg and segment_intersection_assert.svh.
`include "segment_intersection_assert.svh"

module segint_chk import segint_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [1:0] orientation,
  input coord_t            hit_x,
  input coord_t            hit_y
);

  // A miss carries a zero point
  `SI_ASSERT(a_miss_zero, out_valid && orientation == ORIENT_NONE |-> hit_x == '0 && hit_y == '0, "miss with nonzero point")

  // Only the three orientation codes appear
  `SI_ASSERT(a_orient_code, out_valid |-> orientation != 2'sb10, "bad orientation code")

  // Backpressure reaches the input only behind a waiting result
  `SI_ASSERT(a_ready_stall, !in_ready |-> out_valid && !$past(out_ready), "input stalled without a waiting result")

  // A stalled result holds
  `SI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hit_x) && $stable(hit_y), "stalled result changed")

  // Nothing leaves during reset
  `SI_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid, "result during reset")

endmodule

bind segment_intersection segint_chk u_segint_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .orientation (out_o.orientation),
  .hit_x       (out_o.hit_x),
  .hit_y       (out_o.hit_y)
);
